@@ src/mi4_pkg.sv @@
// ----------------------------------------------------------------------------
// mi4_pkg : shared constants and types for the 4x4 matrix inverse core
// Default widths plus the control structs passed between the core and its
// arithmetic units.
// ----------------------------------------------------------------------------
`default_nettype none
package mi4_pkg;

    localparam int MI4_DATA_WIDTH = 32;
    localparam int MI4_FRAC_BITS  = 16;

    // command to the multiply-accumulate unit
    typedef struct packed {
        logic start;
        logic neg;
    } t_mac_cmd;

    // status back from the divider
    typedef struct packed {
        logic done;
        logic sat;
    } t_div_stat;

endpackage
`default_nettype wire

@@ src/mi4_ram.sv @@
// ----------------------------------------------------------------------------
// mi4_ram : generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module mi4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ src/mi4_mac.sv @@
// ----------------------------------------------------------------------------
// mi4_mac : bit-serial signed multiply-accumulate
// acc = init +/- a*b, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module mi4_mac #(
    parameter int DATA_WIDTH = 32,
    parameter int ACC_WIDTH  = 132
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire mi4_pkg::t_mac_cmd        i_cmd,
    input  wire logic [ACC_WIDTH-1:0]     i_a,
    input  wire logic [DATA_WIDTH-1:0]    i_b,
    input  wire logic [ACC_WIDTH-1:0]     i_init,
    output logic                          o_done,
    output logic      [ACC_WIDTH-1:0]     o_acc
);
    import mi4_pkg::*;

    localparam int CNTW = $clog2(DATA_WIDTH);

    logic                  r_run;
    logic                  r_done;
    logic                  r_neg;
    logic [CNTW-1:0]       r_cnt;
    logic [ACC_WIDTH-1:0]  r_ma;
    logic [DATA_WIDTH-1:0] r_mb;
    logic [ACC_WIDTH-1:0]  r_acc;

    logic                  last;
    logic                  sub;
    logic [ACC_WIDTH-1:0]  term;

    // top bit of b carries negative weight
    assign last = (r_cnt == CNTW'(DATA_WIDTH - 1));
    assign sub  = r_neg ^ last;
    assign term = r_mb[0] ? r_ma : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_run <= 1'b1;
            end else if (r_run && last) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_cmd.start) begin
            r_ma  <= i_a;
            r_mb  <= i_b;
            r_acc <= i_init;
            r_neg <= i_cmd.neg;
            r_cnt <= '0;
        end else if (r_run) begin
            r_acc <= r_acc + (term ^ {ACC_WIDTH{sub}}) + ACC_WIDTH'(sub);
            r_ma  <= {r_ma[ACC_WIDTH-2:0], 1'b0};
            r_mb  <= {1'b0, r_mb[DATA_WIDTH-1:1]};
            r_cnt <= r_cnt + CNTW'(1);
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule
`default_nettype wire

@@ src/mi4_div.sv @@
// ----------------------------------------------------------------------------
// mi4_div : restoring divider with output saturation
// trunc(cof * 2^(2F) / det), one quotient bit per cycle, clipped to DATA_WIDTH.
// ----------------------------------------------------------------------------
`default_nettype none
module mi4_div #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int COF_WIDTH  = 98,
    parameter int ACC_WIDTH  = 132
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [COF_WIDTH-1:0]     i_cof,
    input  wire logic [ACC_WIDTH-1:0]     i_det,
    output mi4_pkg::t_div_stat            o_stat,
    output logic      [DATA_WIDTH-1:0]    o_value
);
    import mi4_pkg::*;

    localparam int NW   = COF_WIDTH + 2 * FRAC_BITS;
    localparam int CNTW = $clog2(NW + 1);

    logic                 r_run;
    logic                 r_done;
    logic                 r_neg;
    logic [CNTW-1:0]      r_cnt;
    logic [ACC_WIDTH-1:0] r_rem;
    logic [ACC_WIDTH-1:0] r_d;
    logic [NW-1:0]        r_q;

    logic [ACC_WIDTH:0]   rem2;
    logic [ACC_WIDTH+1:0] diff;
    logic                 ge;
    logic [COF_WIDTH-1:0] cof_mag;
    logic [ACC_WIDTH-1:0] det_mag;
    logic                 hi_nz;
    logic                 at_lim;
    logic                 sat_pos;
    logic                 sat_neg;

    assign rem2    = {r_rem, r_q[NW-1]};
    assign diff    = {1'b0, rem2} - {2'b00, r_d};
    assign ge      = !diff[ACC_WIDTH+1];
    assign cof_mag = i_cof[COF_WIDTH-1] ? (COF_WIDTH'(0) - i_cof) : i_cof;
    assign det_mag = i_det[ACC_WIDTH-1] ? (ACC_WIDTH'(0) - i_det) : i_det;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_cnt == CNTW'(NW - 1))) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_q   <= {cof_mag, {(2 * FRAC_BITS){1'b0}}};
            r_d   <= det_mag;
            r_neg <= i_cof[COF_WIDTH-1] ^ i_det[ACC_WIDTH-1];
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_run) begin
            r_rem <= ge ? diff[ACC_WIDTH-1:0] : rem2[ACC_WIDTH-1:0];
            r_q   <= {r_q[NW-2:0], ge};
            r_cnt <= r_cnt + CNTW'(1);
        end
    end

    // magnitude limit is 2^(DATA_WIDTH-1); exactly that is still legal when negative
    assign hi_nz   = |r_q[NW-1:DATA_WIDTH-1];
    assign at_lim  = r_q[DATA_WIDTH-1] && !(|r_q[NW-1:DATA_WIDTH])
                     && !(|r_q[DATA_WIDTH-2:0]);
    assign sat_pos = !r_neg && hi_nz;
    assign sat_neg = r_neg && hi_nz && !at_lim;

    always_comb begin
        if (sat_pos) begin
            o_value = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end else if (sat_neg) begin
            o_value = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else if (r_neg) begin
            o_value = DATA_WIDTH'(0) - r_q[DATA_WIDTH-1:0];
        end else begin
            o_value = r_q[DATA_WIDTH-1:0];
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.sat  = sat_pos || sat_neg;

endmodule
`default_nettype wire

@@ src/matrix_inverse_4x4_core.sv @@
// ----------------------------------------------------------------------------
// matrix_inverse_4x4_core : 4x4 fixed-point inverse by the adjugate method
// Loads a matrix one element per beat, then streams the 16 inverse elements.
// ----------------------------------------------------------------------------
// Usage
//   Input: drive i_element_value with start high; a beat is taken on an edge
//   where start is high and busy is low. Elements arrive row-major, signed
//   Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS. On the sixteenth beat busy rises and
//   stays high until the last result.
//   Compute: every cofactor is built from element products in a bit-serial
//   MAC fed from the matrix RAM (one read port); each of the 148 MAC ops
//   (144 cofactor terms, 4 determinant terms) steps through S_RDA, S_RDB,
//   S_MUL and S_WAIT, and each cofactor is stored in S_COF. Each result
//   then needs a restoring divide (S_DIVRD, S_DIVGO, S_DIV); a singular
//   matrix skips the divide.
//   Output: each result sits on the o_ ports for one cycle with o_result_valid
//   high; the receiver cannot stall. o_last_result marks the sixteenth.
//   Reset (synchronous, active low) returns to loading at position 0; the
//   matrix and cofactor RAMs are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module matrix_inverse_4x4_core #(
    parameter int DATA_WIDTH = mi4_pkg::MI4_DATA_WIDTH,
    parameter int FRAC_BITS  = mi4_pkg::MI4_FRAC_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [DATA_WIDTH-1:0] i_element_value,
    output logic                       o_result_valid,
    output logic      [DATA_WIDTH-1:0] o_inverse_value,
    output logic                       o_singular,
    output logic                       o_saturated,
    output logic                       o_last_result
);
    import mi4_pkg::*;

    localparam int AW = 4 * DATA_WIDTH + 4;   // accumulator / determinant
    localparam int CW = 3 * DATA_WIDTH + 2;   // stored cofactor

    typedef enum logic [8:0] {
        S_LOAD  = 9'b000000001,
        S_RDA   = 9'b000000010,
        S_RDB   = 9'b000000100,
        S_MUL   = 9'b000001000,
        S_WAIT  = 9'b000010000,
        S_COF   = 9'b000100000,
        S_DIVRD = 9'b001000000,
        S_DIVGO = 9'b010000000,
        S_DIV   = 9'b100000000
    } t_state;

    // MAC operations inside one cofactor term
    typedef enum logic [1:0] {
        OP_MA = 2'd0,   // minor = e*e
        OP_MB = 2'd1,   // minor -= e*e
        OP_CF = 2'd2,   // cof +/-= e*minor
        OP_DT = 2'd3    // det += e*cof
    } t_op;

    function automatic logic [1:0] f_skip(input logic [1:0] n, input logic [1:0] x);
        f_skip = (n < x) ? n : n + 2'd1;
    endfunction

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [3:0]    r_pos, n_pos;
    logic [3:0]    r_k, n_k;
    logic [1:0]    r_g, n_g;
    logic [AW-1:0] r_a, n_a;
    logic [AW-1:0] r_minor, n_minor;
    logic [AW-1:0] r_cof, n_cof;
    logic [AW-1:0] r_det, n_det;
    logic                  r_valid, n_valid;
    logic [DATA_WIDTH-1:0] r_value, n_value;
    logic                  r_sing, n_sing;
    logic                  r_sat, n_sat;
    logic                  r_last, n_last;

    logic [1:0] ri, cj, rw0, rw1, rw2, cu, cv, cg, uidx, vidx;
    logic [3:0] a_addr, b_addr;

    logic                  mat_we;
    logic [3:0]            mat_raddr;
    logic [DATA_WIDTH-1:0] mat_rdata;
    logic                  cof_we;
    logic [CW-1:0]         cof_rdata;
    logic [AW-1:0]         cof_fix;

    t_mac_cmd      mac_cmd;
    logic [AW-1:0] mac_init;
    logic          mac_done;
    logic [AW-1:0] mac_acc;

    logic                  div_start;
    t_div_stat             div_stat;
    logic [DATA_WIDTH-1:0] div_value;

    // cofactor k: row i removed = k[1:0], column j removed = k[3:2]
    // (stored in output order, i.e. already transposed)
    assign ri   = r_k[1:0];
    assign cj   = r_k[3:2];
    assign rw0  = f_skip(2'd0, ri);
    assign rw1  = f_skip(2'd1, ri);
    assign rw2  = f_skip(2'd2, ri);
    assign uidx = (r_g == 2'd0) ? 2'd1 : 2'd0;
    assign vidx = (r_g == 2'd2) ? 2'd1 : 2'd2;
    assign cu   = f_skip(uidx, cj);
    assign cv   = f_skip(vidx, cj);
    assign cg   = f_skip(r_g, cj);

    always_comb begin
        a_addr = (r_op == OP_MA) ? {rw1, cu} : {rw1, cv};
        unique case (r_op)
            OP_MA:   b_addr = {rw2, cv};
            OP_MB:   b_addr = {rw2, cu};
            OP_CF:   b_addr = {rw0, cg};
            OP_DT:   b_addr = {2'd0, cj};
            default: b_addr = '0;
        endcase
    end

    assign mat_we    = (r_state == S_LOAD) && start;
    assign mat_raddr = (r_state == S_RDA) ? a_addr : b_addr;
    assign cof_fix   = (ri[0] ^ cj[0]) ? (AW'(0) - r_cof) : r_cof;
    assign cof_we    = (r_state == S_COF);

    mi4_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (16)
    ) u_mat_ram (
        .i_clk   (i_clk),
        .i_we    (mat_we),
        .i_waddr (r_pos),
        .i_wdata (i_element_value),
        .i_raddr (mat_raddr),
        .o_rdata (mat_rdata)
    );

    mi4_ram #(
        .WIDTH (CW),
        .DEPTH (16)
    ) u_cof_ram (
        .i_clk   (i_clk),
        .i_we    (cof_we),
        .i_waddr (r_k),
        .i_wdata (cof_fix[CW-1:0]),
        .i_raddr (r_k),
        .o_rdata (cof_rdata)
    );

    always_comb begin
        unique case (r_op)
            OP_MA:   mac_init = '0;
            OP_MB:   mac_init = r_minor;
            OP_CF:   mac_init = r_cof;
            OP_DT:   mac_init = r_det;
            default: mac_init = '0;
        endcase
    end

    assign mac_cmd.start = (r_state == S_MUL);
    assign mac_cmd.neg   = (r_op == OP_MB) || ((r_op == OP_CF) && (r_g == 2'd1));

    mi4_mac #(
        .DATA_WIDTH (DATA_WIDTH),
        .ACC_WIDTH  (AW)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mac_cmd),
        .i_a     (r_a),
        .i_b     (mat_rdata),
        .i_init  (mac_init),
        .o_done  (mac_done),
        .o_acc   (mac_acc)
    );

    assign div_start = (r_state == S_DIVGO) && (r_det != '0);

    mi4_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .COF_WIDTH  (CW),
        .ACC_WIDTH  (AW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_cof   (cof_rdata),
        .i_det   (r_det),
        .o_stat  (div_stat),
        .o_value (div_value)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_pos   = r_pos;
        n_k     = r_k;
        n_g     = r_g;
        n_a     = r_a;
        n_minor = r_minor;
        n_cof   = r_cof;
        n_det   = r_det;
        n_valid = 1'b0;
        n_value = r_value;
        n_sing  = r_sing;
        n_sat   = r_sat;
        n_last  = r_last;
        unique case (r_state)
            S_LOAD: begin
                if (start) begin
                    n_pos = r_pos + 4'd1;
                    if (r_pos == 4'd15) begin
                        n_state = S_RDA;
                        n_k     = '0;
                        n_g     = '0;
                        n_op    = OP_MA;
                        n_cof   = '0;
                        n_det   = '0;
                    end
                end
            end
            S_RDA: begin
                n_state = S_RDB;
            end
            S_RDB: begin
                if (r_op == OP_CF) begin
                    n_a = r_minor;
                end else if (r_op == OP_DT) begin
                    n_a = r_cof;
                end else begin
                    n_a = {{(AW-DATA_WIDTH){mat_rdata[DATA_WIDTH-1]}}, mat_rdata};
                end
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (mac_done) begin
                    unique case (r_op)
                        OP_MA: begin
                            n_minor = mac_acc;
                            n_op    = OP_MB;
                            n_state = S_RDA;
                        end
                        OP_MB: begin
                            n_minor = mac_acc;
                            n_op    = OP_CF;
                            n_state = S_RDA;
                        end
                        OP_CF: begin
                            n_cof = mac_acc;
                            if (r_g == 2'd2) begin
                                n_state = S_COF;
                            end else begin
                                n_g     = r_g + 2'd1;
                                n_op    = OP_MA;
                                n_state = S_RDA;
                            end
                        end
                        OP_DT: begin
                            n_det = mac_acc;
                            if (r_k == 4'd15) begin
                                n_k     = '0;
                                n_state = S_DIVRD;
                            end else begin
                                n_k     = r_k + 4'd1;
                                n_g     = '0;
                                n_op    = OP_MA;
                                n_cof   = '0;
                                n_state = S_RDA;
                            end
                        end
                        default: n_state = S_LOAD;
                    endcase
                end
            end
            S_COF: begin
                n_cof = cof_fix;
                if (ri == 2'd0) begin
                    // row-0 cofactor also feeds the determinant
                    n_op    = OP_DT;
                    n_state = S_RDA;
                end else if (r_k == 4'd15) begin
                    n_k     = '0;
                    n_state = S_DIVRD;
                end else begin
                    n_k     = r_k + 4'd1;
                    n_g     = '0;
                    n_op    = OP_MA;
                    n_cof   = '0;
                    n_state = S_RDA;
                end
            end
            S_DIVRD: begin
                n_state = S_DIVGO;
            end
            S_DIVGO: begin
                if (r_det == '0) begin
                    n_valid = 1'b1;
                    n_value = '0;
                    n_sing  = 1'b1;
                    n_sat   = 1'b0;
                    n_last  = (r_k == 4'd15);
                    n_k     = r_k + 4'd1;
                    n_state = (r_k == 4'd15) ? S_LOAD : S_DIVRD;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_valid = 1'b1;
                    n_value = div_value;
                    n_sing  = 1'b0;
                    n_sat   = div_stat.sat;
                    n_last  = (r_k == 4'd15);
                    n_k     = r_k + 4'd1;
                    n_state = (r_k == 4'd15) ? S_LOAD : S_DIVRD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_op    <= OP_MA;
            r_pos   <= '0;
            r_k     <= '0;
            r_g     <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_pos   <= n_pos;
            r_k     <= n_k;
            r_g     <= n_g;
            r_valid <= n_valid;
        end
        r_a     <= n_a;
        r_minor <= n_minor;
        r_cof   <= n_cof;
        r_det   <= n_det;
        r_value <= n_value;
        r_sing  <= n_sing;
        r_sat   <= n_sat;
        r_last  <= n_last;
    end

    assign busy            = (r_state != S_LOAD);
    assign o_result_valid  = r_valid;
    assign o_inverse_value = r_value;
    assign o_singular      = r_sing;
    assign o_saturated     = r_sat;
    assign o_last_result   = r_last;

    // results never come back to back
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("results on consecutive cycles");

    a_sing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_singular) |-> ((o_inverse_value == '0) && !o_saturated))
        else $error("singular result not zero");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_last_result) |-> busy)
        else $error("block idle before last result");

    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (r_pos == 4'd15)) |=> (busy && (r_pos == 4'd0)))
        else $error("sixteenth beat did not start compute");

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench : self-checking bench for matrix_inverse_4x4_core
// Streams matrices in one element per beat. Each inverse is predicted with
// wide exact integer arithmetic and compared field by field with the core's
// result beats.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
    import mi4_pkg::*;

    localparam int DW        = MI4_DATA_WIDTH;
    localparam int FB        = MI4_FRAC_BITS;
    localparam int CYCLE_CAP = 2000000;  // the run is stopped with errors past this cap
    localparam int TAIL_ITEMS = 32;      // final stretch driven back to back
    localparam int HOLD_AT   = 48;       // pause here until the core drains

    typedef logic signed [255:0] t_wide;

    // one expected result beat
    typedef struct {
        logic [DW-1:0] value;
        logic          singular;
        logic          saturated;
        logic          last;
    } t_inv_beat;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic [DW-1:0] i_element_value = '0;
    logic          busy;
    logic          o_result_valid;
    logic [DW-1:0] o_inverse_value;
    logic          o_singular;
    logic          o_saturated;
    logic          o_last_result;

    matrix_inverse_4x4_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_element_value(i_element_value),
        .o_result_valid (o_result_valid),
        .o_inverse_value(o_inverse_value),
        .o_singular     (o_singular),
        .o_saturated    (o_saturated),
        .o_last_result  (o_last_result)
    );

    logic [DW-1:0] element_feed[$];     // elements still to be sent
    t_inv_beat     inverse_expect[$];   // predicted result beats, oldest first
    logic [DW-1:0] held_matrix[16];     // predictor copy of the loaded matrix
    int            held_pos = 0;
    int            accepted_beats = 0;
    int            mismatches = 0;
    int            idle_left = 0;
    int            cycle_count = 0;
    bit            feed_ready = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic t_wide element_at(int r, int c);
        return t_wide'($signed(held_matrix[r * 4 + c]));
    endfunction

    // signed 3x3 cofactor of (i,j), exact
    function automatic t_wide cofactor_of(int i, int j);
        int    rs[3];
        int    cs[3];
        int    n;
        t_wide t;
        n = 0;
        for (int k = 0; k < 4; k++) if (k != i) begin rs[n] = k; n++; end
        n = 0;
        for (int k = 0; k < 4; k++) if (k != j) begin cs[n] = k; n++; end
        t = element_at(rs[0], cs[0]) *
                (element_at(rs[1], cs[1]) * element_at(rs[2], cs[2]) -
                 element_at(rs[1], cs[2]) * element_at(rs[2], cs[1]))
          - element_at(rs[0], cs[1]) *
                (element_at(rs[1], cs[0]) * element_at(rs[2], cs[2]) -
                 element_at(rs[1], cs[2]) * element_at(rs[2], cs[0]))
          + element_at(rs[0], cs[2]) *
                (element_at(rs[1], cs[0]) * element_at(rs[2], cs[1]) -
                 element_at(rs[1], cs[1]) * element_at(rs[2], cs[0]));
        return ((i + j) % 2 == 1) ? -t : t;
    endfunction

    // store one element; on the sixteenth, queue the whole inverse
    task automatic predict_inverse(input logic [DW-1:0] elem);
        t_wide       cof[16];
        t_wide       det;
        logic [255:0] num;
        logic [255:0] dmag;
        logic [255:0] quot;
        logic [255:0] limit;
        bit          neg;
        t_inv_beat   b;
        held_matrix[held_pos] = elem;
        if (held_pos != 15) begin
            held_pos++;
            return;
        end
        held_pos = 0;
        for (int k = 0; k < 16; k++) cof[k] = cofactor_of(k / 4, k % 4);
        det = '0;
        for (int c = 0; c < 4; c++) det = det + element_at(0, c) * cof[c];
        dmag  = det[255] ? -det : det;
        limit = 256'd1 << (DW - 1);
        for (int k = 0; k < 16; k++) begin
            b.last = (k == 15);
            if (det == 0) begin
                b.value = '0; b.singular = 1'b1; b.saturated = 1'b0;
            end else begin
                // transposed cofactor over the determinant
                num  = cof[(k % 4) * 4 + k / 4];
                neg  = num[255] != det[255];
                if (num[255]) num = -num;
                num  = num << (2 * FB);
                quot = num / dmag;
                b.singular = 1'b0;
                if (!neg && quot >= limit) begin
                    b.value = {1'b0, {(DW-1){1'b1}}}; b.saturated = 1'b1;
                end else if (neg && quot > limit) begin
                    b.value = {1'b1, {(DW-1){1'b0}}}; b.saturated = 1'b1;
                end else begin
                    b.value = neg ? DW'(-quot) : DW'(quot); b.saturated = 1'b0;
                end
            end
            inverse_expect.push_back(b);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_matrix(input int kind);
        logic [DW-1:0] m[16];
        for (int k = 0; k < 16; k++) begin
            case (kind)
                0: m[k] = $urandom;                                  // full range
                1: m[k] = DW'($signed($urandom_range(0, 1 << 18)) - (1 << 17))
                          + ((k % 5 == 0) ? DW'(4 << FB) : '0);     // well conditioned
                2: m[k] = DW'($signed($urandom_range(0, 64)) - 32);  // tiny: overflow
                default: m[k] = $urandom_range(0, 3) == 0 ? $urandom
                                : DW'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            endcase
        end
        // singular variant: copy one row onto another
        if (kind == 4) for (int c = 0; c < 4; c++) m[12 + c] = m[4 + c];
        for (int k = 0; k < 16; k++) element_feed.push_back(m[k]);
    endtask

    initial begin
        // identity
        for (int k = 0; k < 16; k++)
            element_feed.push_back((k % 5 == 0) ? DW'(1 << FB) : '0);
        // all zero: singular
        for (int k = 0; k < 16; k++) element_feed.push_back('0);
        // field extremes and smallest steps on the diagonal, -1 LSB or 0 elsewhere
        element_feed.push_back({1'b0, {(DW-1){1'b1}}});
        for (int k = 1; k < 16; k++)
            element_feed.push_back((k % 5 == 0) ? ((k == 10) ? {1'b1, {(DW-1){1'b0}}}
                                   : DW'(1)) : ((k % 2) ? '1 : '0));
        while (element_feed.size() < 176)
            push_matrix($urandom_range(0, 4));
        feed_ready = 1;
    end

    // driver: one beat per accepted element, random idle bursts
    always @(posedge i_clk) begin
        logic          nxt_start;
        logic [DW-1:0] nxt_value;
        nxt_start = start;
        nxt_value = i_element_value;
        if (i_rst_n && feed_ready) begin
            if (start && !busy) begin
                predict_inverse(i_element_value);
                void'(element_feed.pop_front());
                accepted_beats++;
                nxt_start = 1'b0;
            end
            if (!(start && busy)) begin
                if (idle_left > 0)
                    idle_left--;
                else if (element_feed.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0)
                    idle_left = $urandom_range(1, 16) - 1;
                else if (accepted_beats == HOLD_AT && inverse_expect.size() != 0)
                    ;  // let the core drain completely once
                else if (element_feed.size() != 0) begin
                    nxt_start = 1'b1;
                    nxt_value = element_feed[0];
                end
            end
        end
        start           <= nxt_start;
        i_element_value <= nxt_value;
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_inv_beat e;
        if (i_rst_n && o_result_valid) begin
            if (inverse_expect.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: value %h", o_inverse_value);
            end else begin
                e = inverse_expect.pop_front();
                if (o_inverse_value !== e.value || o_singular !== e.singular ||
                    o_saturated !== e.saturated || o_last_result !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h s%b t%b l%b got %h s%b t%b l%b",
                                 e.value, e.singular, e.saturated, e.last, o_inverse_value,
                                 o_singular, o_saturated, o_last_result);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (feed_ready);
        while (element_feed.size() != 0 || inverse_expect.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && inverse_expect.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
`default_nettype wire

@@ matrix_inverse_4x4_core.f @@
src/mi4_pkg.sv
src/mi4_ram.sv
src/mi4_mac.sv
src/mi4_div.sv
src/matrix_inverse_4x4_core.sv
bench/testbench.sv
